// ----- rtl/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg
// shared widths, reset values and direction codes of the renko brick builder
// ----------------------------------------------------------------------------
`default_nettype none

package rbb_pkg;

  localparam int PriceBits   = 32;
  localparam int TimeBits    = 64;
  localparam int HeightBits  = 24;
  localparam int VolBits     = 32;
  localparam int AddrBits    = 3;
  localparam int DataBits    = 32;

  localparam logic [HeightBits-1:0] HeightReset = HeightBits'(100);

  typedef enum logic {
    DIR_LONG  = 1'b0,
    DIR_SHORT = 1'b1
  } dir_e;

  typedef enum logic {
    REG_HEIGHT = 1'b0,
    REG_NONE   = 1'b1
  } reg_e;

endpackage

`default_nettype wire

// ----- rtl/renko_brick_builder_top.sv -----
// ----------------------------------------------------------------------------
// renko_brick_builder_top
// turns a bid/ask tick stream into fixed-height renko bricks
// ----------------------------------------------------------------------------
// Takes one tick word per clock while the brick side does not stall, and
// gives at most one brick word per tick. A tick lands in the input register,
// and its brick in the result register once that register is free; a stall
// on the brick side holds the tick in the input register. The rate is set by
// the update of the brick state (anchor, last open/close, tick count), which
// each tick reads and writes before the next one is evaluated. Ticks with a
// zero bid or ask are dropped silently. The user must write brick_height over
// the APB port at byte address 0 while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module renko_brick_builder_top
  import rbb_pkg::*;
#(
  parameter int PRICE_BITS = PriceBits,
  parameter int TIME_BITS  = TimeBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [AddrBits-1:0]   paddr,
  input  wire logic [DataBits-1:0]   pwdata,
  output logic      [DataBits-1:0]   prdata,
  output logic                       pready,

  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [TIME_BITS-1:0]  tick_time_i,
  input  wire logic [PRICE_BITS-1:0] bid_price_i,
  input  wire logic [PRICE_BITS-1:0] ask_price_i,

  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       direction_o,
  output logic      [PRICE_BITS-1:0] brick_open_o,
  output logic      [PRICE_BITS-1:0] brick_close_o,
  output logic      [PRICE_BITS-1:0] brick_high_o,
  output logic      [PRICE_BITS-1:0] brick_low_o,
  output logic      [TIME_BITS-1:0]  open_stamp_o,
  output logic      [TIME_BITS-1:0]  close_stamp_o,
  output logic      [VolBits-1:0]    tick_volume_o
);

  localparam int DiffBits = (PRICE_BITS > HeightBits) ? PRICE_BITS : HeightBits;
  localparam logic [VolBits-1:0] VolMax = '1;

  // configuration
  logic [HeightBits-1:0] height_q;
  reg_e                  reg_sel;

  assign reg_sel = reg_e'(paddr[AddrBits-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightReset;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_HEIGHT) begin
      height_q <= pwdata[HeightBits-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HEIGHT: prdata = DataBits'(height_q);
      default:    prdata = '0;
    endcase
  end

  // input register
  logic                  s1_valid_q;
  logic [TIME_BITS-1:0]  s1_time_q;
  logic [PRICE_BITS-1:0] s1_bid_q;
  logic [PRICE_BITS-1:0] s1_ask_q;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_take;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_time_q <= tick_time_i;
      s1_bid_q  <= bid_price_i;
      s1_ask_q  <= ask_price_i;
    end
  end

  // brick state
  logic                  have_brick_q;
  logic                  anchor_seen_q;
  logic [PRICE_BITS-1:0] anchor_price_q;
  logic [TIME_BITS-1:0]  anchor_time_q;
  logic [VolBits-1:0]    tick_count_q;
  dir_e                  last_dir_q;
  logic [PRICE_BITS-1:0] last_open_q;
  logic [PRICE_BITS-1:0] last_close_q;
  logic [TIME_BITS-1:0]  last_open_time_q;
  logic [TIME_BITS-1:0]  last_close_time_q;

  // single-pass evaluation
  logic                  tick_ok;
  logic [PRICE_BITS-1:0] up_ref;
  logic [PRICE_BITS-1:0] dn_ref;
  logic [TIME_BITS-1:0]  up_time;
  logic [TIME_BITS-1:0]  dn_time;
  logic [DiffBits-1:0]   up_diff;
  logic [DiffBits-1:0]   dn_diff;
  logic                  up_hit;
  logic                  dn_hit;
  logic                  emit;
  dir_e                  emit_dir;
  logic [PRICE_BITS-1:0] emit_open;
  logic [PRICE_BITS-1:0] emit_close;
  logic [TIME_BITS-1:0]  emit_otime;
  logic [DiffBits-1:0]   close_wide;
  logic [VolBits-1:0]    count_inc;
  logic [VolBits-1:0]    count_d;

  assign tick_ok = (s1_bid_q != '0) && (s1_ask_q != '0);

  always_comb begin
    if (!have_brick_q) begin
      up_ref  = anchor_price_q;
      dn_ref  = anchor_price_q;
      up_time = anchor_time_q;
      dn_time = anchor_time_q;
    end else if (last_dir_q == DIR_LONG) begin
      up_ref  = last_close_q;
      dn_ref  = last_open_q;
      up_time = last_close_time_q;
      dn_time = last_open_time_q;
    end else begin
      up_ref  = last_open_q;
      dn_ref  = last_close_q;
      up_time = last_open_time_q;
      dn_time = last_close_time_q;
    end
  end

  assign up_diff = DiffBits'(s1_bid_q) - DiffBits'(up_ref);
  assign dn_diff = DiffBits'(dn_ref) - DiffBits'(s1_bid_q);
  assign up_hit  = (s1_bid_q > up_ref) && (up_diff >= DiffBits'(height_q));
  assign dn_hit  = (s1_bid_q < dn_ref) && (dn_diff >= DiffBits'(height_q));

  always_comb begin
    emit     = 1'b0;
    emit_dir = DIR_LONG;
    if (tick_ok && (have_brick_q || anchor_seen_q)) begin
      priority if (have_brick_q && last_dir_q == DIR_SHORT && dn_hit) begin
        emit     = 1'b1;
        emit_dir = DIR_SHORT;
      end else if (up_hit) begin
        emit     = 1'b1;
        emit_dir = DIR_LONG;
      end else if (dn_hit) begin
        emit     = 1'b1;
        emit_dir = DIR_SHORT;
      end else begin
        emit     = 1'b0;
        emit_dir = DIR_LONG;
      end
    end
  end

  assign emit_open  = (emit_dir == DIR_LONG) ? up_ref : dn_ref;
  assign emit_otime = (emit_dir == DIR_LONG) ? up_time : dn_time;
  assign close_wide = (emit_dir == DIR_LONG) ?
                      DiffBits'(emit_open) + DiffBits'(height_q) :
                      DiffBits'(emit_open) - DiffBits'(height_q);
  assign emit_close = close_wide[PRICE_BITS-1:0];

  assign count_inc = (tick_count_q != VolMax) ? tick_count_q + VolBits'(1) : VolMax;

  always_comb begin
    if (!have_brick_q) begin
      count_d = count_inc;
    end else if (tick_count_q == '0) begin
      count_d = VolBits'(2);
    end else begin
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_brick_q  <= 1'b0;
      anchor_seen_q <= 1'b0;
      tick_count_q  <= '0;
      last_dir_q    <= DIR_LONG;
    end else if (s1_fire && tick_ok) begin
      anchor_seen_q <= 1'b1;
      if (emit && have_brick_q) begin
        tick_count_q <= '0;
      end else begin
        tick_count_q <= count_d;
      end
      if (emit) begin
        have_brick_q <= 1'b1;
        last_dir_q   <= emit_dir;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && tick_ok) begin
      if (!have_brick_q && !anchor_seen_q) begin
        anchor_price_q <= s1_bid_q;
        anchor_time_q  <= s1_time_q;
      end
      if (emit) begin
        last_open_q       <= emit_open;
        last_close_q      <= emit_close;
        last_open_time_q  <= emit_otime;
        last_close_time_q <= s1_time_q;
      end
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      direction_o   <= emit_dir;
      brick_open_o  <= emit_open;
      brick_close_o <= emit_close;
      brick_high_o  <= (emit_dir == DIR_LONG) ? emit_close : emit_open;
      brick_low_o   <= (emit_dir == DIR_LONG) ? emit_open : emit_close;
      open_stamp_o  <= emit_otime;
      close_stamp_o <= s1_time_q;
      tick_volume_o <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- verif/tb_renko_brick_builder_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_renko_brick_builder_top
// tick stream against renko brick predictor
// ----------------------------------------------------------------------------
// Feeds bid/ask ticks into the brick builder and predicts every brick the
// block should emit from its own copy of the anchor, the last brick and the
// tick count. Directed ticks cover invalid ticks, the anchor, the first brick,
// extend and reverse in both directions, price extremes and the zero, unit
// and largest brick heights. A back-pressure test fills the block while the
// brick side holds off. Random phases then walk prices around the brick edges
// under several heights with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_renko_brick_builder_top
  import rbb_pkg::*;
();

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 8;
  localparam int PhaseTicks   = 100;
  localparam logic [AddrBits-1:0] HeightAddr = AddrBits'(4 * int'(REG_HEIGHT));

  typedef struct {
    dir_e                 dir;
    logic [PriceBits-1:0] open_px;
    logic [PriceBits-1:0] close_px;
    logic [PriceBits-1:0] high_px;
    logic [PriceBits-1:0] low_px;
    logic [TimeBits-1:0]  open_ts;
    logic [TimeBits-1:0]  close_ts;
    logic [VolBits-1:0]   volume;
  } brick_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrBits-1:0]  paddr       = '0;
  logic [DataBits-1:0]  pwdata      = '0;
  logic [DataBits-1:0]  prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [TimeBits-1:0]  tick_time_i = '0;
  logic [PriceBits-1:0] bid_price_i = '0;
  logic [PriceBits-1:0] ask_price_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 direction_o;
  logic [PriceBits-1:0] brick_open_o;
  logic [PriceBits-1:0] brick_close_o;
  logic [PriceBits-1:0] brick_high_o;
  logic [PriceBits-1:0] brick_low_o;
  logic [TimeBits-1:0]  open_stamp_o;
  logic [TimeBits-1:0]  close_stamp_o;
  logic [VolBits-1:0]   tick_volume_o;

  renko_brick_builder_top u_dut (.*);

  always #10 clk_i = ~clk_i;

  // brick state mirror
  logic [HeightBits-1:0] height_q     = HeightReset;
  bit                    built_any    = 1'b0;
  bit                    anchor_set   = 1'b0;
  logic [PriceBits-1:0]  anchor_px    = '0;
  logic [TimeBits-1:0]   anchor_ts    = '0;
  logic [VolBits-1:0]    vol_count    = '0;
  dir_e                  run_dir      = DIR_LONG;
  logic [PriceBits-1:0]  run_open     = '0;
  logic [PriceBits-1:0]  run_close    = '0;
  logic [TimeBits-1:0]   run_open_ts  = '0;
  logic [TimeBits-1:0]   run_close_ts = '0;

  brick_t expected_bricks[$];
  int     mismatches = 0;
  int     hold_req   = 0;
  bit     calm       = 1'b0;

  function automatic logic [VolBits-1:0] sat_inc(logic [VolBits-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [PriceBits-1:0] clamp_px(longint v);
    if (v < 1) return 1;
    if (v > longint'(32'hFFFF_FFFF)) return '1;
    return v[PriceBits-1:0];
  endfunction

  function automatic void push_brick(dir_e dir, logic [PriceBits-1:0] open_px,
                                     logic [TimeBits-1:0] ots, logic [TimeBits-1:0] cts);
    brick_t b;
    b.dir      = dir;
    b.open_px  = open_px;
    b.close_px = (dir == DIR_SHORT) ? open_px - PriceBits'(height_q)
                                    : open_px + PriceBits'(height_q);
    b.high_px  = (dir == DIR_SHORT) ? b.open_px : b.close_px;
    b.low_px   = (dir == DIR_SHORT) ? b.close_px : b.open_px;
    b.open_ts  = ots;
    b.close_ts = cts;
    b.volume   = vol_count;
    expected_bricks = {expected_bricks, b};
    built_any    = 1'b1;
    run_dir      = dir;
    run_open     = b.open_px;
    run_close    = b.close_px;
    run_open_ts  = ots;
    run_close_ts = cts;
  endfunction

  task automatic predict_brick(input logic [TimeBits-1:0] ts,
                               input logic [PriceBits-1:0] bid, ask);
    logic [PriceBits-1:0] h;
    h = PriceBits'(height_q);
    if (bid == 0 || ask == 0) return;
    if (!built_any) begin
      vol_count = sat_inc(vol_count);
      if (!anchor_set) begin
        anchor_set = 1'b1;
        anchor_px  = bid;
        anchor_ts  = ts;
        return;
      end
      if (bid > anchor_px && bid - anchor_px >= h) begin
        push_brick(DIR_LONG, anchor_px, anchor_ts, ts);
      end else if (bid < anchor_px && anchor_px - bid >= h) begin
        push_brick(DIR_SHORT, anchor_px, anchor_ts, ts);
      end
      return;
    end
    vol_count = (vol_count == 0) ? VolBits'(2) : sat_inc(vol_count);
    if (run_dir == DIR_LONG) begin
      if (bid > run_close && bid - run_close >= h) begin
        push_brick(DIR_LONG, run_close, run_close_ts, ts);
        vol_count = '0;
      end else if (bid < run_open && run_open - bid >= h) begin
        push_brick(DIR_SHORT, run_open, run_open_ts, ts);
        vol_count = '0;
      end
    end else begin
      if (bid < run_close && run_close - bid >= h) begin
        push_brick(DIR_SHORT, run_close, run_close_ts, ts);
        vol_count = '0;
      end else if (bid > run_open && bid - run_open >= h) begin
        push_brick(DIR_LONG, run_open, run_open_ts, ts);
        vol_count = '0;
      end
    end
  endtask

  task automatic offer_tick(input logic [TimeBits-1:0] ts,
                            input logic [PriceBits-1:0] bid, ask);
    tick_time_i <= ts;
    bid_price_i <= bid;
    ask_price_i <= ask;
    in_valid_i  <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_brick(ts, bid, ask);
  endtask

  task automatic sender_gap(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_bricks();
    in_valid_i <= 1'b0;
    while (expected_bricks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_height(input logic [DataBits-1:0] word);
    drain_bricks();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HeightAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    height_q = word[HeightBits-1:0];
  endtask

  // next price that completes a brick in the current run, or reverses near the rails
  function automatic logic [PriceBits-1:0] trend_bid();
    longint hl;
    hl = longint'(height_q);
    if (!built_any) return clamp_px(longint'(anchor_px) + hl);
    if (run_dir == DIR_LONG) begin
      if (longint'(run_close) + hl <= longint'(32'hFFFF_FFFF))
        return clamp_px(longint'(run_close) + hl);
      return clamp_px(longint'(run_open) - hl);
    end
    if (longint'(run_close) - hl >= 1) return clamp_px(longint'(run_close) - hl);
    return clamp_px(longint'(run_open) + hl);
  endfunction

  task automatic test_reset_height();
    offer_tick(64'h0, 32'h0, 32'h0);
    offer_tick(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    offer_tick(64'h10, 32'd1000, 32'd1001);
    offer_tick(64'h20, 32'd1099, 32'd1100);
    offer_tick(64'h30, 32'd901, 32'd902);
    offer_tick(64'h40, 32'd1000, 32'h0);
    offer_tick(64'h50, 32'd1100, 32'd1101);
    offer_tick(64'h60, 32'd1199, 32'd1200);
    offer_tick(64'h70, 32'd1350, 32'd1351);
    offer_tick(64'h80, 32'd1101, 32'd1102);
    offer_tick(64'h90, 32'd1000, 32'd1001);
    offer_tick(64'hA0, 32'd901, 32'd902);
    offer_tick(64'hB0, 32'd900, 32'd901);
    offer_tick(64'hC0, 32'd1100, 32'd1101);
    offer_tick(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_tick(64'h0, 32'd1, 32'd1);
  endtask

  task automatic test_height_extremes();
    write_height(32'h0000_0000);
    offer_tick(64'h1000, run_close, 32'd7);
    offer_tick(64'h1010, clamp_px(longint'(run_close) - 1), 32'd7);
    offer_tick(64'h1020, clamp_px(longint'(run_close) + 1), 32'd7);
    write_height(32'hA500_0001);
    offer_tick(64'h1030, clamp_px(longint'(run_close) + 1), 32'd9);
    offer_tick(64'h1040, clamp_px(longint'(run_open) - 1), 32'd9);
    write_height(32'h00FF_FFFF);
    offer_tick(64'h5555_5555_5555_5555, 32'hFFFF_FFFF, 32'h8000_0000);
    offer_tick(64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0001, 32'h7FFF_FFFF);
    offer_tick(64'h1050, 32'h8000_0000, 32'h5555_5555);
  endtask

  task automatic test_backpressure();
    write_height(32'd1);
    hold_req = hold_req + 1;
    repeat (40) offer_tick(run_close_ts + 64'd3, trend_bid(), 32'hAAAA_AAAA);
    drain_bricks();
  endtask

  task automatic test_random_ticks();
    longint               px;
    longint               hl;
    longint               hw;
    longint               base;
    logic [TimeBits-1:0]  ts;
    logic [PriceBits-1:0] bid;
    logic [PriceBits-1:0] ask;
    logic [DataBits-1:0]  word;
    int                   r;
    int                   k;
    int                   idle_pct;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: word = $urandom_range(1, 20);
        1: word = $urandom;
        2: word = 32'd100;
        3: word = $urandom_range(1, 2000);
        4: word = {8'($urandom), 24'hFF_FFFF};
        5: word = 32'd1;
        default: word = $urandom_range(1, 500);
      endcase
      idle_pct = (p % 3) * 20;
      if (p == 6) begin
        calm     = 1'b1;
        idle_pct = 0;
      end
      write_height(word);
      px = built_any ? longint'(run_close) : longint'($urandom_range(1000, 100000));
      ts = {$urandom, $urandom};
      for (int i = 0; i < PhaseTicks; i++) begin
        hl = longint'(height_q);
        hw = (hl == 0) ? 1 : hl;
        ts = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : ts + $urandom_range(1, 5000);
        ask = $urandom;
        if (ask == 0) ask = 1;
        bid = clamp_px(px + longint'($urandom_range(0, 32'(4 * hw))) - 2 * hw);
        r = $urandom_range(0, 99);
        if (r < 4) begin
          bid = '0;
        end else if (r < 7) begin
          ask = '0;
        end else if (r < 10) begin
          bid = $urandom;
        end else if (r < 40) begin
          // land on or next to a brick edge
          base = ($urandom_range(0, 1) == 1) ? longint'(built_any ? run_close : anchor_px)
                                             : longint'(built_any ? run_open : anchor_px);
          k    = $urandom_range(0, 2) - 1;
          bid  = ($urandom_range(0, 1) == 1) ? clamp_px(base + hl + k)
                                             : clamp_px(base - hl - k);
        end
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          sender_gap($urandom_range(1, 12));
        offer_tick(ts, bid, ask);
        if (bid != 0 && ask != 0) px = longint'(bid);
      end
    end
  endtask

  // brick side back-pressure
  int hold_seen  = 0;
  int hold_left  = 0;
  int burst_left = 0;
  int clear_left = 0;

  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (clear_left > 0) begin
      clear_left--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      burst_left = $urandom_range(1, 12) - 1;
      out_stall_i <= 1'b1;
    end else begin
      clear_left = $urandom_range(1, 30) - 1;
      out_stall_i <= 1'b0;
    end
  end

  function automatic int field_diff(string tag, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : check_bricks
    brick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bricks.size() == 0) begin
        $display("%0t: brick word with none expected, actual open %h close %h",
                 $time, brick_open_o, brick_close_o);
        mismatches++;
      end else begin
        want = expected_bricks.pop_front();
        mismatches += field_diff("direction", want.dir, direction_o)
                    + field_diff("brick_open", want.open_px, brick_open_o)
                    + field_diff("brick_close", want.close_px, brick_close_o)
                    + field_diff("brick_high", want.high_px, brick_high_o)
                    + field_diff("brick_low", want.low_px, brick_low_o)
                    + field_diff("open_stamp", want.open_ts, open_stamp_o)
                    + field_diff("close_stamp", want.close_ts, close_stamp_o)
                    + field_diff("tick_volume", want.volume, tick_volume_o);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_height();
    test_height_extremes();
    test_backpressure();
    test_random_ticks();
    drain_bricks();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
